>>> rtl/bm25_pkg.sv
// Shared constants, types and codes of the BM25 ranking engine.
package bm25_pkg;

    localparam int MAX_CHUNKS = 4096;
    localparam int TOP_MAX    = 16;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int SCAN_W     = $clog2(MAX_CHUNKS + 1);
    localparam int TOP_W      = $clog2(TOP_MAX);
    localparam int CNT_W      = $clog2(TOP_MAX + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int DIV_STEPS  = 64;

    localparam logic [31:0] ONE_Q16 = 32'd65536;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [6:0]  SERIES_LIMIT = 7'd99;

    typedef enum logic [1:0] {
        CMD_LEN  = 2'd0,
        CMD_TERM = 2'd1,
        CMD_POST = 2'd2,
        CMD_EMIT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_TERM_SAT_K     = 2'd0,
        REG_LENGTH_WEIGHT  = 2'd1,
        REG_AVERAGE_LENGTH = 2'd2,
        REG_CHUNK_TOTAL    = 2'd3
    } t_reg;

    typedef struct packed {
        t_cmd              cmd;
        logic [IDX_W-1:0]  idx;
        logic [15:0]       arg;
    } t_entry;

    typedef struct packed {
        logic [17:0] term_sat_k;
        logic [16:0] length_weight;
        logic [31:0] average_length;
        logic [12:0] chunk_total;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_WAIT,
        S_T_NORM,
        S_T_ZDIV,
        S_T_Z2,
        S_T_SQ,
        S_T_CHK,
        S_T_PMUL,
        S_T_PDIV,
        S_T_PACC,
        S_T_FIN,
        S_P_RDIV,
        S_P_BR,
        S_P_NORM,
        S_P_KN,
        S_P_NUM,
        S_P_QDIV,
        S_P_MUL,
        S_P_WR,
        S_E_SCAN,
        S_E_DRAIN,
        S_E_OUT
    } t_state;

endpackage

>>> rtl/bm25_front.sv
// Input stage: accepts words, clamps arguments and hands commands to the queue.
module bm25_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_cmd,
    input  logic [11:0]                i_chunk_index,
    input  logic [15:0]                i_chunk_length,
    input  logic [12:0]                i_doc_freq,
    input  logic [15:0]                i_term_freq,
    input  logic [4:0]                 i_result_count,
    input  logic [12:0]                i_chunk_total,
    input  logic                       i_hold,
    input  logic                       i_full,
    output logic                       o_push,
    output bm25_pkg::t_entry           o_entry
);

    logic             r_valid;
    logic             n_valid;
    bm25_pkg::t_entry r_entry;
    bm25_pkg::t_entry cls;
    logic             accept;
    logic             keep;

    assign o_push  = r_valid && !i_full;
    assign o_stall = i_hold || (r_valid && i_full);
    assign accept  = i_valid && !o_stall;
    assign o_entry = r_entry;

    always_comb begin
        cls.cmd = bm25_pkg::t_cmd'(i_cmd);
        cls.idx = i_chunk_index;
        keep    = 1'b1;
        case (cls.cmd)
            bm25_pkg::CMD_LEN: begin
                cls.arg = i_chunk_length;
                keep    = 32'(i_chunk_index) < bm25_pkg::MAX_CHUNKS;
            end
            bm25_pkg::CMD_TERM: begin
                cls.arg = (i_doc_freq > i_chunk_total) ? 16'(i_chunk_total) : 16'(i_doc_freq);
            end
            bm25_pkg::CMD_POST: begin
                cls.arg = i_term_freq;
                keep    = 32'(i_chunk_index) < bm25_pkg::MAX_CHUNKS;
            end
            default: begin
                cls.arg = (32'(i_result_count) > bm25_pkg::TOP_MAX) ?
                          16'(bm25_pkg::TOP_MAX) : 16'(i_result_count);
            end
        endcase
    end

    always_comb begin
        if (accept && keep) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= cls;
        end
    end

endmodule

>>> rtl/bm25_fifo.sv
// Short command queue between the input stage and the execution core.
module bm25_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bm25_pkg::t_entry i_data,
    input  logic             i_pop,
    output bm25_pkg::t_entry o_data,
    output logic             o_empty,
    output logic             o_full
);

    bm25_pkg::t_entry                 r_mem [bm25_pkg::FIFO_DEPTH];
    logic [bm25_pkg::FIFO_AW-1:0]     r_wp;
    logic [bm25_pkg::FIFO_AW-1:0]     r_rp;
    logic [bm25_pkg::FIFO_AW:0]       r_count;

    assign o_empty = r_count == '0;
    assign o_full  = r_count == (bm25_pkg::FIFO_AW + 1)'(bm25_pkg::FIFO_DEPTH);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count out of step");

endmodule

>>> rtl/bm25_div.sv
// Restoring divider, one quotient bit per cycle.
module bm25_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [63:0]         i_num,
    input  logic [39:0]         i_den,
    output bm25_pkg::t_div_stat o_stat,
    output logic [63:0]         o_quo
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [39:0] r_rem;
    logic [39:0] r_den;
    logic [63:0] r_quo;
    logic [40:0] trial;
    logic [40:0] diff;
    logic        fits;

    assign trial = {r_rem, r_quo[63]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == 6'(bm25_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= fits ? diff[39:0] : trial[39:0];
            r_quo <= {r_quo[62:0], fits};
        end
    end

endmodule

>>> rtl/bm25_core.sv
// Execution core: length and score stores, idf and posting arithmetic, top-k scan.
module bm25_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bm25_pkg::t_cfg   i_cfg,
    input  bm25_pkg::t_entry i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_clearing,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_found,
    output logic [11:0]      o_ranked_chunk,
    output logic [31:0]      o_score,
    output logic             o_last
);

    localparam int IW = bm25_pkg::IDX_W;
    localparam int SW = bm25_pkg::SCAN_W;
    localparam int TW = bm25_pkg::TOP_W;
    localparam int CW = bm25_pkg::CNT_W;
    localparam int TM = bm25_pkg::TOP_MAX;

    logic [15:0] r_len_mem [bm25_pkg::MAX_CHUNKS];
    logic [32:0] r_sc_mem  [bm25_pkg::MAX_CHUNKS];
    logic [15:0] r_len_rd;
    logic [32:0] r_sc_rd;

    logic          len_we, len_re, sc_we, sc_re;
    logic [IW-1:0] len_addr, sc_ra, sc_wa;
    logic [15:0]   len_wd;
    logic [32:0]   sc_wd;

    bm25_pkg::t_state r_state, n_state, r_ret, n_ret;
    bm25_pkg::t_entry r_op, n_op;
    logic [SW-1:0]    r_cnt, n_cnt;
    logic [31:0]      r_idf, n_idf;
    logic [15:0]      r_a, n_a, r_b, n_b;
    logic [3:0]       r_e, n_e;
    logic [31:0]      r_z, n_z, r_z2, n_z2, r_p, n_p;
    logic [33:0]      r_s, n_s;
    logic [6:0]       r_k, n_k;
    logic [32:0]      r_br, n_br;
    logic [33:0]      r_norm, n_norm;
    logic [35:0]      r_kn, n_kn;
    logic [34:0]      r_num, n_num;
    logic             r_dz, n_dz;
    logic [47:0]      r_add, n_add;
    logic [CW-1:0]    r_kk, n_kk, r_best_n, n_best_n, r_ptr, n_ptr;
    logic [IW-1:0]    r_best_idx [TM];
    logic [IW-1:0]    n_best_idx [TM];
    logic [31:0]      r_best_sc  [TM];
    logic [31:0]      n_best_sc  [TM];
    logic             r_rd_v;
    logic [IW-1:0]    r_rd_idx;
    logic             r_ovalid, n_ovalid;
    logic             r_ofound, n_ofound, r_olast, n_olast;
    logic [IW-1:0]    r_oidx, n_oidx;
    logic [31:0]      r_osc, n_osc;

    logic                div_start;
    logic [63:0]         div_num;
    logic [39:0]         div_den;
    bm25_pkg::t_div_stat div_stat;
    logic [63:0]         div_quo;

    logic [16:0] b_eff;
    logic [31:0] avg_eff;
    logic [49:0] mul_br;
    logic [51:0] mul_kn;
    logic [63:0] mul_w;
    logic [39:0] den_q;
    logic [39:0] v_sum;
    logic [48:0] sc_sum;
    logic [31:0] q32;

    logic [TM-1:0] ge;
    logic          ins_ok;
    logic [CW-1:0] ins_n;
    logic [IW-1:0] ins_idx [TM];
    logic [31:0]   ins_sc  [TM];
    logic          out_free;

    bm25_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    assign b_eff   = (i_cfg.length_weight > 17'(bm25_pkg::ONE_Q16)) ?
                     17'(bm25_pkg::ONE_Q16) : i_cfg.length_weight;
    assign avg_eff = (i_cfg.average_length < bm25_pkg::ONE_Q16) ?
                     bm25_pkg::ONE_Q16 : i_cfg.average_length;

    assign o_clearing     = r_state == bm25_pkg::S_CLEAR;
    assign o_valid        = r_ovalid;
    assign o_found        = r_ofound;
    assign o_ranked_chunk = 12'(r_oidx);
    assign o_score        = r_osc;
    assign o_last         = r_olast;
    assign out_free       = !r_ovalid || !i_stall;

    // sorted insertion of the chunk read back during the scan
    always_comb begin
        for (int j = 0; j < TM; j++) begin
            ge[j] = (CW'(j) < r_best_n) && (r_best_sc[j] >= r_sc_rd[31:0]);
        end
        ins_ok = r_rd_v && r_sc_rd[32] && (r_kk != '0) && !ge[TW'(r_kk - 1'b1)];
        ins_n  = (r_best_n < r_kk) ? r_best_n + 1'b1 : r_best_n;
        if (ge[0]) begin
            ins_idx[0] = r_best_idx[0];
            ins_sc[0]  = r_best_sc[0];
        end else begin
            ins_idx[0] = r_rd_idx;
            ins_sc[0]  = r_sc_rd[31:0];
        end
        for (int j = 1; j < TM; j++) begin
            if (ge[j]) begin
                ins_idx[j] = r_best_idx[j];
                ins_sc[j]  = r_best_sc[j];
            end else if (ge[j-1]) begin
                ins_idx[j] = r_rd_idx;
                ins_sc[j]  = r_sc_rd[31:0];
            end else begin
                ins_idx[j] = r_best_idx[j-1];
                ins_sc[j]  = r_best_sc[j-1];
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_op     = r_op;
        n_cnt    = r_cnt;
        n_idf    = r_idf;
        n_a      = r_a;
        n_b      = r_b;
        n_e      = r_e;
        n_z      = r_z;
        n_z2     = r_z2;
        n_p      = r_p;
        n_s      = r_s;
        n_k      = r_k;
        n_br     = r_br;
        n_norm   = r_norm;
        n_kn     = r_kn;
        n_num    = r_num;
        n_dz     = r_dz;
        n_add    = r_add;
        n_kk     = r_kk;
        n_best_n = r_best_n;
        n_ptr    = r_ptr;
        n_best_idx = r_best_idx;
        n_best_sc  = r_best_sc;
        n_ovalid = r_ovalid && i_stall;
        n_ofound = r_ofound;
        n_olast  = r_olast;
        n_oidx   = r_oidx;
        n_osc    = r_osc;
        o_pop    = 1'b0;
        len_we   = 1'b0;
        len_re   = 1'b0;
        len_addr = r_op.idx;
        len_wd   = i_head.arg;
        sc_we    = 1'b0;
        sc_re    = 1'b0;
        sc_ra    = r_op.idx;
        sc_wa    = r_op.idx;
        sc_wd    = '0;
        div_start = 1'b0;
        div_num  = '0;
        div_den  = '0;
        mul_br   = 50'(b_eff) * 50'(div_quo[31:0]);
        mul_kn   = 52'(i_cfg.term_sat_k) * 52'(r_norm);
        den_q    = 40'({r_op.arg, 16'b0}) + 40'(r_kn);
        q32      = r_dz ? 32'd0 : div_quo[31:0];
        mul_w    = '0;
        v_sum    = 40'(r_e) * 40'(bm25_pkg::LN2_Q32) + {5'b0, r_s, 1'b0};
        sc_sum   = 49'(r_sc_rd[31:0]) + 49'(r_add);

        case (r_state)
            bm25_pkg::S_CLEAR: begin
                sc_we = 1'b1;
                sc_wa = r_cnt[IW-1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SW'(bm25_pkg::MAX_CHUNKS - 1)) begin
                    n_state = bm25_pkg::S_IDLE;
                end
            end
            bm25_pkg::S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_op  = i_head;
                    case (i_head.cmd)
                        bm25_pkg::CMD_LEN: begin
                            len_we   = 1'b1;
                            len_addr = i_head.idx;
                        end
                        bm25_pkg::CMD_TERM: begin
                            n_a     = 16'({i_cfg.chunk_total, 1'b0}) + 16'd2;
                            n_b     = 16'({i_head.arg[12:0], 1'b1});
                            n_e     = '0;
                            n_state = bm25_pkg::S_T_NORM;
                        end
                        bm25_pkg::CMD_POST: begin
                            len_re   = 1'b1;
                            sc_re    = 1'b1;
                            len_addr = i_head.idx;
                            sc_ra    = i_head.idx;
                            n_state  = bm25_pkg::S_P_RDIV;
                        end
                        default: begin
                            n_kk     = i_head.arg[CW-1:0];
                            n_best_n = '0;
                            n_cnt    = '0;
                            n_state  = bm25_pkg::S_E_SCAN;
                        end
                    endcase
                end
            end
            bm25_pkg::S_DIV_WAIT: begin
                if (div_stat.done) begin
                    n_state = r_ret;
                end
            end
            bm25_pkg::S_T_NORM: begin
                if (17'(r_a) >= {r_b, 1'b0}) begin
                    n_b = {r_b[14:0], 1'b0};
                    n_e = r_e + 1'b1;
                end else begin
                    n_state = bm25_pkg::S_T_ZDIV;
                end
            end
            bm25_pkg::S_T_ZDIV: begin
                div_start = 1'b1;
                div_num   = {16'b0, r_a - r_b, 32'b0};
                div_den   = 40'(17'(r_a) + 17'(r_b));
                n_ret     = bm25_pkg::S_T_Z2;
                n_state   = bm25_pkg::S_DIV_WAIT;
            end
            bm25_pkg::S_T_Z2: begin
                n_z     = div_quo[31:0];
                n_p     = div_quo[31:0];
                n_s     = 34'(div_quo[31:0]);
                n_k     = 7'd3;
                n_state = bm25_pkg::S_T_SQ;
            end
            bm25_pkg::S_T_SQ: begin
                mul_w   = 64'(r_z) * 64'(r_z);
                n_z2    = mul_w[63:32];
                n_state = bm25_pkg::S_T_CHK;
            end
            bm25_pkg::S_T_CHK: begin
                if (r_k < bm25_pkg::SERIES_LIMIT && r_p != '0) begin
                    n_state = bm25_pkg::S_T_PMUL;
                end else begin
                    n_state = bm25_pkg::S_T_FIN;
                end
            end
            bm25_pkg::S_T_PMUL: begin
                mul_w   = 64'(r_p) * 64'(r_z2);
                n_p     = mul_w[63:32];
                n_state = bm25_pkg::S_T_PDIV;
            end
            bm25_pkg::S_T_PDIV: begin
                div_start = 1'b1;
                div_num   = 64'(r_p);
                div_den   = 40'(r_k);
                n_ret     = bm25_pkg::S_T_PACC;
                n_state   = bm25_pkg::S_DIV_WAIT;
            end
            bm25_pkg::S_T_PACC: begin
                n_s     = r_s + 34'(div_quo[31:0]);
                n_k     = r_k + 7'd2;
                n_state = bm25_pkg::S_T_CHK;
            end
            bm25_pkg::S_T_FIN: begin
                n_idf   = 32'((v_sum + 40'd32768) >> 16);
                n_state = bm25_pkg::S_IDLE;
            end
            bm25_pkg::S_P_RDIV: begin
                div_start = 1'b1;
                div_num   = {16'b0, r_len_rd, 32'b0};
                div_den   = 40'(avg_eff);
                n_ret     = bm25_pkg::S_P_BR;
                n_state   = bm25_pkg::S_DIV_WAIT;
            end
            bm25_pkg::S_P_BR: begin
                n_br    = 33'(mul_br >> 16);
                n_state = bm25_pkg::S_P_NORM;
            end
            bm25_pkg::S_P_NORM: begin
                n_norm  = 34'(bm25_pkg::ONE_Q16) - 34'(b_eff) + 34'(r_br);
                n_state = bm25_pkg::S_P_KN;
            end
            bm25_pkg::S_P_KN: begin
                n_kn    = 36'(mul_kn >> 16);
                n_state = bm25_pkg::S_P_NUM;
            end
            bm25_pkg::S_P_NUM: begin
                n_num   = 35'(r_op.arg) * 35'(19'(i_cfg.term_sat_k) + 19'(bm25_pkg::ONE_Q16));
                n_state = bm25_pkg::S_P_QDIV;
            end
            bm25_pkg::S_P_QDIV: begin
                div_start = 1'b1;
                div_num   = {13'b0, r_num, 16'b0};
                div_den   = den_q;
                n_dz      = den_q == '0;
                n_ret     = bm25_pkg::S_P_MUL;
                n_state   = bm25_pkg::S_DIV_WAIT;
            end
            bm25_pkg::S_P_MUL: begin
                mul_w   = 64'(r_idf) * 64'(q32);
                n_add   = mul_w[63:16];
                n_state = bm25_pkg::S_P_WR;
            end
            bm25_pkg::S_P_WR: begin
                sc_we   = 1'b1;
                sc_wd   = {1'b1, (sc_sum[48:32] != '0) ? 32'hFFFF_FFFF : sc_sum[31:0]};
                n_state = bm25_pkg::S_IDLE;
            end
            bm25_pkg::S_E_SCAN: begin
                sc_re = 1'b1;
                sc_we = 1'b1;
                sc_ra = r_cnt[IW-1:0];
                sc_wa = r_cnt[IW-1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SW'(bm25_pkg::MAX_CHUNKS - 1)) begin
                    n_state = bm25_pkg::S_E_DRAIN;
                end
            end
            bm25_pkg::S_E_DRAIN: begin
                n_ptr   = '0;
                n_state = bm25_pkg::S_E_OUT;
            end
            bm25_pkg::S_E_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    if (r_best_n == '0) begin
                        n_ofound = 1'b0;
                        n_oidx   = '0;
                        n_osc    = '0;
                        n_olast  = 1'b1;
                        n_state  = bm25_pkg::S_IDLE;
                    end else begin
                        n_ofound = 1'b1;
                        n_oidx   = r_best_idx[r_ptr[TW-1:0]];
                        n_osc    = r_best_sc[r_ptr[TW-1:0]];
                        n_olast  = (r_ptr + 1'b1) == r_best_n;
                        n_ptr    = r_ptr + 1'b1;
                        if ((r_ptr + 1'b1) == r_best_n) begin
                            n_state = bm25_pkg::S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = bm25_pkg::S_IDLE;
            end
        endcase

        if (ins_ok) begin
            n_best_n   = ins_n;
            n_best_idx = ins_idx;
            n_best_sc  = ins_sc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bm25_pkg::S_CLEAR;
            r_cnt    <= '0;
            r_idf    <= '0;
            r_ovalid <= 1'b0;
            r_rd_v   <= 1'b0;
            r_best_n <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_idf    <= n_idf;
            r_ovalid <= n_ovalid;
            r_rd_v   <= r_state == bm25_pkg::S_E_SCAN;
            r_best_n <= n_best_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret      <= n_ret;
        r_op       <= n_op;
        r_a        <= n_a;
        r_b        <= n_b;
        r_e        <= n_e;
        r_z        <= n_z;
        r_z2       <= n_z2;
        r_p        <= n_p;
        r_s        <= n_s;
        r_k        <= n_k;
        r_br       <= n_br;
        r_norm     <= n_norm;
        r_kn       <= n_kn;
        r_num      <= n_num;
        r_dz       <= n_dz;
        r_add      <= n_add;
        r_kk       <= n_kk;
        r_ptr      <= n_ptr;
        r_best_idx <= n_best_idx;
        r_best_sc  <= n_best_sc;
        r_rd_idx   <= sc_ra;
        r_ofound   <= n_ofound;
        r_olast    <= n_olast;
        r_oidx     <= n_oidx;
        r_osc      <= n_osc;
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len_mem[len_addr] <= len_wd;
        end
        if (len_re) begin
            r_len_rd <= r_len_mem[len_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sc_we) begin
            r_sc_mem[sc_wa] <= sc_wd;
        end
        if (sc_re) begin
            r_sc_rd <= r_sc_mem[sc_ra];
        end
    end

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");
    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bm25_pkg::S_E_OUT) |-> (r_best_n <= r_kk))
        else $error("best list longer than k");
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == bm25_pkg::S_E_OUT)
        else $error("result word loaded outside emit");

endmodule

>>> rtl/bm25_score_top_k.sv
// Top level of the BM25 ranking engine: register port, input stage, queue, core.
//
// Input words (i_valid / o_stall) carry one command each: 0 loads a chunk
// length, 1 starts a query term, 2 adds a posting, 3 emits the ranking.
// Result words (o_valid / i_stall) appear only for command 3: up to k
// words by descending score, o_last on the final one, or one word with
// o_found low when nothing was scored or k is zero.
// A word taken passes the input-stage register and the queue before it reaches
// the core. Core work, paced by the shared one-bit-per-cycle divider (64 steps):
//   length load  a single store write
//   term start   normalization shifts, one division and one squaring, then
//                one multiply and one division per series term
//   posting      two divisions plus four multiplies
//   emit         a scan of the whole score store, then the result words in order
// After reset all 4096 entries of the score store are cleared; o_stall stays
// high meanwhile. Register writes are taken at any time.
// A stalled result word holds its value; the core waits before loading the
// next one, while the input stage and queue keep taking words.
module bm25_score_top_k (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [11:0] i_chunk_index,
    input  logic [15:0] i_chunk_length,
    input  logic [12:0] i_doc_freq,
    input  logic [15:0] i_term_freq,
    input  logic [4:0]  i_result_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [11:0] o_ranked_chunk,
    output logic [31:0] o_score,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bm25_pkg::t_cfg   r_cfg;
    bm25_pkg::t_entry front_entry;
    bm25_pkg::t_entry head;
    logic             push;
    logic             pop;
    logic             empty;
    logic             full;
    logic             clearing;
    logic             wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.term_sat_k     <= 18'd98304;
            r_cfg.length_weight  <= 17'd49152;
            r_cfg.average_length <= 32'd65536;
            r_cfg.chunk_total    <= 13'd0;
        end else if (wr) begin
            case (bm25_pkg::t_reg'(paddr[3:2]))
                bm25_pkg::REG_TERM_SAT_K:     r_cfg.term_sat_k     <= pwdata[17:0];
                bm25_pkg::REG_LENGTH_WEIGHT:  r_cfg.length_weight  <= pwdata[16:0];
                bm25_pkg::REG_AVERAGE_LENGTH: r_cfg.average_length <= pwdata;
                bm25_pkg::REG_CHUNK_TOTAL:    r_cfg.chunk_total    <= pwdata[12:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (bm25_pkg::t_reg'(paddr[3:2]))
            bm25_pkg::REG_TERM_SAT_K:     prdata = 32'(r_cfg.term_sat_k);
            bm25_pkg::REG_LENGTH_WEIGHT:  prdata = 32'(r_cfg.length_weight);
            bm25_pkg::REG_AVERAGE_LENGTH: prdata = r_cfg.average_length;
            bm25_pkg::REG_CHUNK_TOTAL:    prdata = 32'(r_cfg.chunk_total);
            default:                      prdata = '0;
        endcase
    end

    bm25_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_chunk_index  (i_chunk_index),
        .i_chunk_length (i_chunk_length),
        .i_doc_freq     (i_doc_freq),
        .i_term_freq    (i_term_freq),
        .i_result_count (i_result_count),
        .i_chunk_total  (r_cfg.chunk_total),
        .i_hold         (clearing),
        .i_full         (full),
        .o_push         (push),
        .o_entry        (front_entry)
    );

    bm25_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_entry),
        .i_pop   (pop),
        .o_data  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    bm25_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (head),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_found        (o_found),
        .o_ranked_chunk (o_ranked_chunk),
        .o_score        (o_score),
        .o_last         (o_last)
    );

endmodule

>>> tb/bm25_checker.sv
// Checker for the BM25 ranking engine: tracks registers, predicts ranked words, compares.
module bm25_checker
    import bm25_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [11:0] i_chunk_index,
    input  logic [15:0] i_chunk_length,
    input  logic [12:0] i_doc_freq,
    input  logic [15:0] i_term_freq,
    input  logic [4:0]  i_result_count,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic        o_found,
    input  logic [11:0] o_ranked_chunk,
    input  logic [31:0] o_score,
    input  logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_words_checked
);

    typedef struct packed {
        logic        found;
        logic [11:0] chunk;
        logic [31:0] score;
        logic        last;
    } t_rank_word;

    logic [17:0] k1_q;
    logic [16:0] b_q;
    logic [31:0] avg_q;
    logic [12:0] n_q;
    logic [15:0] len_mem [MAX_CHUNKS];
    logic [31:0] score_mem [MAX_CHUNKS];
    bit          touched [MAX_CHUNKS];
    logic [31:0] idf_q;
    t_rank_word  ranking_q[$];

    assign o_pending = ranking_q.size();

    function automatic logic [31:0] ln_ratio(longint unsigned a, longint unsigned b);
        longint unsigned e, z, z2, p, s, v, kk;
        e = 0;
        while (a >= (b << 1)) begin
            b = b << 1;
            e++;
        end
        z  = ((a - b) << 32) / (a + b);
        z2 = (z * z) >> 32;
        s  = z;
        p  = z;
        for (kk = 3; kk < 99 && p != 0; kk += 2) begin
            p = (p * z2) >> 32;
            s += p / kk;
        end
        v = e * 64'd2977044472 + 2 * s;
        return 32'((v + 64'd32768) >> 16);
    endfunction

    function automatic void start_term(longint unsigned df);
        longint unsigned n;
        n = n_q;
        if (df > n) df = n;
        idf_q = ln_ratio(2 * n + 2, 2 * df + 1);
    endfunction

    function automatic void add_posting(int idx, longint unsigned tf);
        longint unsigned avg, b, k1, dl, r, br, norm, kn, num, den, q, add, sum;
        avg  = (avg_q < ONE_Q16) ? 64'(ONE_Q16) : 64'(avg_q);
        b    = (b_q > ONE_Q16) ? 64'(ONE_Q16) : 64'(b_q);
        k1   = k1_q;
        dl   = len_mem[idx];
        r    = (dl << 32) / avg;
        br   = (b * r) >> 16;
        norm = 64'd65536 - b + br;
        kn   = (k1 * norm) >> 16;
        num  = tf * (k1 + 64'd65536);
        den  = (tf << 16) + kn;
        q    = (den == 0) ? 64'd0 : (num << 16) / den;
        add  = (64'(idf_q) * q) >> 16;
        sum  = 64'(score_mem[idx]) + add;
        score_mem[idx] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        touched[idx] = 1'b1;
    endfunction

    function automatic void rank_touched(int kin);
        int          k, cnt, pos, j;
        logic [11:0] bidx [TOP_MAX];
        logic [31:0] bsc [TOP_MAX];
        t_rank_word  w;
        k   = (kin > TOP_MAX) ? TOP_MAX : kin;
        cnt = 0;
        if (k > 0) begin
            for (int i = 0; i < MAX_CHUNKS; i++) begin
                if (touched[i]) begin
                    pos = cnt;
                    while (pos > 0 && score_mem[i] > bsc[pos-1]) pos--;
                    if (pos < k) begin
                        if (cnt < k) cnt++;
                        for (j = cnt - 1; j > pos; j--) begin
                            bidx[j] = bidx[j-1];
                            bsc[j]  = bsc[j-1];
                        end
                        bidx[pos] = 12'(i);
                        bsc[pos]  = score_mem[i];
                    end
                end
            end
        end
        for (int i = 0; i < MAX_CHUNKS; i++) begin
            score_mem[i] = '0;
            touched[i]   = 1'b0;
        end
        if (cnt == 0) begin
            w = '{found: 1'b0, chunk: 12'd0, score: 32'd0, last: 1'b1};
            ranking_q = {ranking_q, w};
        end else begin
            for (j = 0; j < cnt; j++) begin
                w = '{found: 1'b1, chunk: bidx[j], score: bsc[j], last: (j + 1 == cnt)};
                ranking_q = {ranking_q, w};
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_rank_word w;
        if (!i_rst_n) begin
            k1_q  = 18'd98304;
            b_q   = 17'd49152;
            avg_q = 32'd65536;
            n_q   = 13'd0;
            idf_q = '0;
            for (int i = 0; i < MAX_CHUNKS; i++) begin
                score_mem[i] = '0;
                touched[i]   = 1'b0;
            end
            ranking_q.delete();
            o_fail_count    <= 0;
            o_words_checked <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg'(paddr[3:2]))
                    REG_TERM_SAT_K:     k1_q  = pwdata[17:0];
                    REG_LENGTH_WEIGHT:  b_q   = pwdata[16:0];
                    REG_AVERAGE_LENGTH: avg_q = pwdata;
                    REG_CHUNK_TOTAL:    n_q   = pwdata[12:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                case (t_cmd'(i_cmd))
                    CMD_LEN:  len_mem[i_chunk_index] = i_chunk_length;
                    CMD_TERM: start_term(i_doc_freq);
                    CMD_POST: add_posting(i_chunk_index, i_term_freq);
                    CMD_EMIT: rank_touched(i_result_count);
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                o_words_checked <= o_words_checked + 1;
                if (ranking_q.size() == 0) begin
                    $display("%0t: unexpected ranked word found=%0d chunk=%0d score=%0h last=%0d",
                             $time, o_found, o_ranked_chunk, o_score, o_last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    w = ranking_q.pop_front();
                    if (w.found !== o_found || w.chunk !== o_ranked_chunk ||
                        w.score !== o_score || w.last !== o_last) begin
                        $display("%0t: mismatch expected found=%0d chunk=%0d score=%0h last=%0d",
                                 $time, w.found, w.chunk, w.score, w.last);
                        $display("%0t:          actual   found=%0d chunk=%0d score=%0h last=%0d",
                                 $time, o_found, o_ranked_chunk, o_score, o_last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> tb/testbench.sv
// Top of the BM25 ranking engine testbench: clock, reset, stimulus and verdict.
module testbench;
    import bm25_pkg::*;

    localparam int STALL_LIMIT = 40000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_cmd = '0;
    logic [11:0] i_chunk_index = '0;
    logic [15:0] i_chunk_length = '0;
    logic [12:0] i_doc_freq = '0;
    logic [15:0] i_term_freq = '0;
    logic [4:0]  i_result_count = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_found;
    logic [11:0] o_ranked_chunk;
    logic [31:0] o_score;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count, pending, words_checked;
    int tx_pct = 0;
    int rx_pct = 0;
    int n_items = 0;
    int n_writes = 0;
    int idle_cycles = 0;
    int loaded_q[$];

    bm25_score_top_k dut (.*);

    bm25_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_cmd, .i_chunk_index, .i_chunk_length,
        .i_doc_freq, .i_term_freq, .i_result_count, .o_valid, .i_stall, .o_found,
        .o_ranked_chunk, .o_score, .o_last, .psel, .penable, .pwrite, .paddr, .pwdata,
        .pready, .o_fail_count(fail_count), .o_pending(pending),
        .o_words_checked(words_checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= (rx_pct > 0) && ($urandom_range(99) < rx_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send(input t_cmd c, input int idx, input int len, input int df,
                        input int tf, input int k);
        while (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= c;
        i_chunk_index  <= 12'(idx);
        i_chunk_length <= 16'(len);
        i_doc_freq     <= 13'(df);
        i_term_freq    <= 16'(tf);
        i_result_count <= 5'(k);
        do @(posedge i_clk); while (o_stall);
        n_items++;
    endtask

    // noise in fields the command does not use
    task automatic load_len(input int idx, input int len);
        send(CMD_LEN, idx, len, $urandom, $urandom, $urandom);
        loaded_q = {loaded_q, idx};
    endtask

    task automatic term(input int df);
        send(CMD_TERM, $urandom, $urandom, df, $urandom, $urandom);
    endtask

    task automatic post(input int idx, input int tf);
        send(CMD_POST, idx, $urandom, $urandom, tf, $urandom);
    endtask

    task automatic emit(input int k);
        send(CMD_EMIT, $urandom, $urandom, $urandom, $urandom, k);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic reg_write(input t_reg r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_writes++;
    endtask

    task automatic configure(input int k1, input int b, input logic [31:0] avg, input int n);
        reg_write(REG_TERM_SAT_K, k1);
        reg_write(REG_LENGTH_WEIGHT, b);
        reg_write(REG_AVERAGE_LENGTH, avg);
        reg_write(REG_CHUNK_TOTAL, n);
    endtask

    function automatic int pick_loaded();
        return loaded_q[$urandom_range(loaded_q.size() - 1)];
    endfunction

    function automatic int rand_tf();
        case ($urandom_range(3))
            0: return $urandom_range(1, 4);
            1: return 65535;
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    initial begin
        int budget, nload, npost, idx, sel;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        configure(98304, 49152, 32'd65536, 4096);
        tx_pct = 34;
        rx_pct = 46;
        load_len(0, 0);
        load_len(4095, 65535);
        load_len(5, 100);
        load_len(7, 0);
        post(5, 3);                 // posting with no term yet: zero idf
        term(1);
        post(0, 65535);
        post(4095, 1);
        term(4096);
        post(5, 1);
        emit(0);                    // k zero: not found
        emit(16);                   // nothing touched: not found
        term(1);
        post(7, 7);
        post(0, 7);                 // tie with chunk 7, lower index first
        post(4095, 2);
        emit(31);                   // k above the maximum
        drain();
        configure(0, 131071, 32'd0, 3);   // weight above one, average below one
        term(10);                   // doc frequency above chunk total
        post(4095, 2);
        post(0, 0);                 // zero denominator
        emit(1);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            tx_pct = (phase == 0) ? 34 : (phase == 1) ? 46 : 0;
            rx_pct = (phase == 0) ? 46 : (phase == 1) ? 34 : 0;
            for (int s = 0; s < 3; s++) begin
                if (phase == 0 && s == 0) configure(0, 0, 32'd65536, 0);
                else if (phase == 1 && s == 0)
                    configure(262143, 65536, 32'hFFFF_FFFF, 4096);
                else configure($urandom_range(262143), $urandom_range(65536),
                               $urandom_range(32'hFFFF_FFFF, 32'd65536),
                               $urandom_range(4096));
                budget = n_items + 44;
                while (n_items < budget) begin
                    nload = $urandom_range(1, 4);
                    for (int j = 0; j < nload; j++) begin
                        sel = $urandom_range(9);
                        idx = (sel == 0) ? 0 : (sel == 1) ? 4095 :
                              (sel < 5) ? $urandom_range(15) : $urandom_range(4095);
                        load_len(idx, $urandom_range(1) ? $urandom_range(65535)
                                                        : $urandom_range(300));
                    end
                    for (int t = 0; t < $urandom_range(1, 2); t++) begin
                        term($urandom_range(3) == 0 ? $urandom_range(1, 4096)
                                                    : $urandom_range(1, 40));
                        npost = $urandom_range(2, 8);
                        for (int j = 0; j < npost; j++) post(pick_loaded(), rand_tf());
                    end
                    if ($urandom_range(9) == 0) begin
                        // stray command between queries
                        sel = $urandom_range(2);
                        if (sel == 0) load_len($urandom_range(4095), $urandom_range(65535));
                        else if (sel == 1) post(pick_loaded(), rand_tf());
                        else emit($urandom_range(31));
                    end
                    emit($urandom_range(7) == 0 ? $urandom_range(31) : $urandom_range(1, 16));
                end
                drain();
            end
        end

        $display("Ran %0d input words and %0d register writes over 9 settings and 3 idling modes,",
                 n_items, n_writes);
        $display("checked %0d ranked words.", words_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> bm25_score_top_k.f
rtl/bm25_pkg.sv
rtl/bm25_front.sv
rtl/bm25_fifo.sv
rtl/bm25_div.sv
rtl/bm25_core.sv
rtl/bm25_score_top_k.sv
tb/bm25_checker.sv
tb/testbench.sv
